// File: hdl/ttsb_pkg.sv
`timescale 1ns / 1ps

package ttsb_pkg;

  // Screen geometry
  localparam int COLUMNS = 14;
  localparam int ROWS    = 4;
  localparam int CELLS   = COLUMNS * ROWS;

  // Cell address, cursor position, row and column widths
  localparam int CELL_AW = $clog2(CELLS);
  localparam int POS_W   = $clog2(CELLS + 1);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int COL_W   = $clog2(COLUMNS);

  // Character codes
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_LF    = 8'd10;

  // Colours after reset
  localparam logic [15:0] FORE_RST = 16'hFFFF;
  localparam logic [15:0] BACK_RST = 16'h0000;

  // Item modes
  localparam logic [2:0] MODE_PUT    = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_CLEAR  = 3'd2;
  localparam logic [2:0] MODE_SCROLL = 3'd3;
  localparam logic [2:0] MODE_POLL   = 3'd4;

  // Configuration register indexes
  localparam int         CFG_IDX_W = 1;
  localparam logic [0:0] REG_FORE  = 1'b0;
  localparam logic [0:0] REG_BACK  = 1'b1;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] char_code;
    logic [5:0] cell_index;
    logic [7:0] scroll_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [15:0] cell_fore;
    logic [15:0] cell_back;
    logic [5:0]  cursor_pos;
    logic        dirty_flag;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [15:0] fg;
    logic [15:0] bg;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_INIT,
    DP_FILL,
    DP_COPY,
    DP_TOP,
    DP_BLANK,
    DP_PUT,
    DP_LF,
    DP_READ,
    DP_SCR
  } dp_op_t;

  // Sweep pointer start points
  typedef enum logic [1:0] {
    PTR_ZERO,
    PTR_ROW1,
    PTR_LAST_ROW
  } ptr_sel_t;

  typedef struct packed {
    dp_op_t   op;
    logic     load;
    logic     ptr_ld;
    ptr_sel_t ptr_sel;
    logic     cnt_dec;
    logic     resp_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       is_lf;
    logic       cur_full;
    logic       cur_row0;
    logic       ptr_last;
    logic       ptr_row_end;
    logic       cnt_zero;
    logic       cnt_one;
  } dp_stat_t;

endpackage

// File: hdl/ttsb_ram.sv
`timescale 1ns / 1ps

module ttsb_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 56,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/ttsb_dp.sv
`timescale 1ns / 1ps

module ttsb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ttsb_pkg::dp_cmd_t                 cmd,
  output ttsb_pkg::dp_stat_t                stat,
  input  ttsb_pkg::in_item_t                in_data,
  output ttsb_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [ttsb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [15:0]                       cfg_data
);
  import ttsb_pkg::*;

  // Item and response registers
  in_item_t  item_r, item_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  out_item_t out_r, out_nxt;

  // Cursor kept as row, column and row start
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] base_r, base_nxt;
  logic             dirty_r, dirty_nxt;

  // Colour registers
  logic [15:0] fore_r, fore_nxt;
  logic [15:0] back_r, back_nxt;

  // Sweep pointer and the delayed write of a read-modify-write
  logic [POS_W-1:0]   ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_blank_r, pend_blank_nxt;
  logic [CELL_AW-1:0] waddr_r, waddr_nxt;

  // Store port signals
  logic               ram_we;
  logic [CELL_AW-1:0] ram_waddr;
  cell_t              ram_wdata;
  logic               ram_re;
  logic [CELL_AW-1:0] ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;
  cell_t              rd_cell;

  logic [POS_W-1:0] cur_pos;
  logic [7:0]       ch_eff;
  logic             read_hit;

  ttsb_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_cell  = ram_rdata;
  assign cur_pos  = base_r + POS_W'(col_r);
  assign ch_eff   = (item_r.char_code == 8'd0) ? CH_SPACE : item_r.char_code;
  assign read_hit = (item_r.mode == MODE_READ) && (int'(item_r.cell_index) < CELLS);

  // Status toward the controller
  always_comb begin
    stat.mode        = item_r.mode;
    stat.is_lf       = (item_r.char_code == CH_LF);
    stat.cur_full    = (row_r == ROW_W'(ROWS));
    stat.cur_row0    = (row_r == '0);
    stat.ptr_last    = (ptr_r == POS_W'(CELLS - 1));
    stat.ptr_row_end = (ptr_r == POS_W'(COLUMNS - 1));
    stat.cnt_zero    = (cnt_r == 8'd0);
    stat.cnt_one     = (cnt_r == 8'd1);
  end

  // Datapath next-state logic
  always_comb begin
    item_nxt       = item_r;
    cnt_nxt        = cnt_r;
    out_nxt        = out_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    base_nxt       = base_r;
    dirty_nxt      = dirty_r;
    fore_nxt       = fore_r;
    back_nxt       = back_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = 1'b0;
    pend_blank_nxt = 1'b0;
    waddr_nxt      = waddr_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    if (cfg_we) begin
      case (cfg_index)
        REG_FORE: fore_nxt = cfg_data;
        REG_BACK: back_nxt = cfg_data;
        default:  ;
      endcase
    end

    if (cmd.load) begin
      item_nxt = in_data;
      cnt_nxt  = in_data.scroll_count;
    end

    case (cmd.op)
      DP_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = CELL_AW'(ptr_r);
        ram_wdata = '{ch: CH_SPACE, fg: FORE_RST, bg: BACK_RST};
        ptr_nxt   = ptr_r + 1'b1;
      end
      DP_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = CELL_AW'(ptr_r);
        ram_wdata = '{ch: CH_SPACE, fg: fore_r, bg: back_r};
        ptr_nxt   = ptr_r + 1'b1;
        row_nxt   = '0;
        col_nxt   = '0;
        base_nxt  = '0;
        dirty_nxt = 1'b1;
      end
      DP_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = CELL_AW'(ptr_r);
        ram_wdata = '{ch: CH_SPACE, fg: fore_r, bg: back_r};
        ptr_nxt   = ptr_r + 1'b1;
      end
      DP_COPY: begin
        // read one row down, write it back a row up in the next cycle
        ram_re    = 1'b1;
        ram_raddr = CELL_AW'(ptr_r);
        ptr_nxt   = ptr_r + 1'b1;
        pend_nxt  = 1'b1;
        waddr_nxt = CELL_AW'(ptr_r - POS_W'(COLUMNS));
      end
      DP_TOP: begin
        // top row: keep colours, blank the character
        ram_re         = 1'b1;
        ram_raddr      = CELL_AW'(ptr_r);
        ptr_nxt        = ptr_r + 1'b1;
        pend_nxt       = 1'b1;
        pend_blank_nxt = 1'b1;
        waddr_nxt      = CELL_AW'(ptr_r);
      end
      DP_READ: begin
        ram_re    = 1'b1;
        ram_raddr = CELL_AW'(item_r.cell_index);
      end
      DP_SCR: begin
        col_nxt = '0;
        if (row_r != '0) begin
          if (row_r >= ROW_W'(ROWS - 1)) begin
            row_nxt  = ROW_W'(ROWS - 1);
            base_nxt = POS_W'(CELLS - COLUMNS);
          end
          dirty_nxt = 1'b1;
        end
      end
      DP_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = CELL_AW'(cur_pos);
        ram_wdata = '{ch: ch_eff, fg: fore_r, bg: back_r};
        dirty_nxt = 1'b1;
        if (col_r == COL_W'(COLUMNS - 1)) begin
          col_nxt  = '0;
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + POS_W'(COLUMNS);
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      DP_LF: begin
        // saturates once the cursor is past the end
        if (row_r < ROW_W'(ROWS)) begin
          row_nxt  = row_r + 1'b1;
          base_nxt = base_r + POS_W'(COLUMNS);
          col_nxt  = '0;
        end
      end
      default: ;
    endcase

    // delayed write of a copied or blanked cell
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = waddr_r;
      ram_wdata = rd_cell;
      if (pend_blank_r) begin
        ram_wdata.ch = CH_SPACE;
      end
    end

    if (cmd.ptr_ld) begin
      case (cmd.ptr_sel)
        PTR_ZERO:     ptr_nxt = '0;
        PTR_ROW1:     ptr_nxt = POS_W'(COLUMNS);
        PTR_LAST_ROW: ptr_nxt = POS_W'(CELLS - COLUMNS);
        default:      ptr_nxt = '0;
      endcase
    end

    if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - 8'd1;
    end

    // result item; poll reports dirty before clearing it
    if (cmd.resp_ld) begin
      out_nxt.cell_char  = read_hit ? rd_cell.ch : 8'd0;
      out_nxt.cell_fore  = read_hit ? rd_cell.fg : 16'd0;
      out_nxt.cell_back  = read_hit ? rd_cell.bg : 16'd0;
      out_nxt.cursor_pos = 6'(cur_pos);
      out_nxt.dirty_flag = dirty_r;
      if (item_r.mode == MODE_POLL) begin
        dirty_nxt = 1'b0;
      end
    end
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      base_r       <= '0;
      dirty_r      <= 1'b0;
      fore_r       <= FORE_RST;
      back_r       <= BACK_RST;
      ptr_r        <= '0;
      pend_r       <= 1'b0;
      pend_blank_r <= 1'b0;
    end else begin
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
      dirty_r      <= dirty_nxt;
      fore_r       <= fore_nxt;
      back_r       <= back_nxt;
      ptr_r        <= ptr_nxt;
      pend_r       <= pend_nxt;
      pend_blank_r <= pend_blank_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    cnt_r   <= cnt_nxt;
    out_r   <= out_nxt;
    waddr_r <= waddr_nxt;
  end

  assign out_data = out_r;

endmodule

// File: hdl/ttsb_ctrl.sv
`timescale 1ns / 1ps

module ttsb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ttsb_pkg::dp_stat_t stat,
  output ttsb_pkg::dp_cmd_t  cmd
);
  import ttsb_pkg::*;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_SCR,
    ST_COPY,
    ST_COPY_DRAIN,
    ST_BLANK,
    ST_TOP,
    ST_TOP_DRAIN,
    ST_SCR_END,
    ST_PUT,
    ST_FILL,
    ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '{op: DP_NOP, load: 1'b0, ptr_ld: 1'b0, ptr_sel: PTR_ZERO,
                      cnt_dec: 1'b0, resp_ld: 1'b0};

    case (state_r)
      ST_INIT: begin
        cmd.op = DP_INIT;
        if (stat.ptr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.mode)
          MODE_PUT: begin
            if (stat.is_lf) begin
              cmd.op    = DP_LF;
              state_nxt = ST_RESP;
            end else if (stat.cur_full) begin
              state_nxt = ST_SCR;
            end else begin
              state_nxt = ST_PUT;
            end
          end
          MODE_READ: begin
            cmd.op    = DP_READ;
            state_nxt = ST_RESP;
          end
          MODE_CLEAR: begin
            cmd.ptr_ld  = 1'b1;
            cmd.ptr_sel = PTR_ZERO;
            state_nxt   = ST_FILL;
          end
          MODE_SCROLL: begin
            state_nxt = stat.cnt_zero ? ST_RESP : ST_SCR;
          end
          default: state_nxt = ST_RESP;
        endcase
      end
      // one scroll: top-row blank when on row 0, else shift all rows up and blank the last row
      ST_SCR: begin
        cmd.op     = DP_SCR;
        cmd.ptr_ld = 1'b1;
        if (stat.cur_row0) begin
          cmd.ptr_sel = PTR_ZERO;
          state_nxt   = ST_TOP;
        end else begin
          cmd.ptr_sel = PTR_ROW1;
          state_nxt   = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.op = DP_COPY;
        if (stat.ptr_last) begin
          cmd.ptr_ld  = 1'b1;
          cmd.ptr_sel = PTR_LAST_ROW;
          state_nxt   = ST_COPY_DRAIN;
        end
      end
      ST_COPY_DRAIN: state_nxt = ST_BLANK;
      ST_BLANK: begin
        cmd.op = DP_BLANK;
        if (stat.ptr_last) begin
          state_nxt = ST_SCR_END;
        end
      end
      ST_TOP: begin
        cmd.op = DP_TOP;
        if (stat.ptr_row_end) begin
          state_nxt = ST_TOP_DRAIN;
        end
      end
      ST_TOP_DRAIN: state_nxt = ST_SCR_END;
      ST_SCR_END: begin
        if (stat.mode == MODE_PUT) begin
          state_nxt = ST_PUT;
        end else if (stat.cnt_one) begin
          state_nxt = ST_RESP;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = ST_SCR;
        end
      end
      ST_PUT: begin
        cmd.op    = DP_PUT;
        state_nxt = ST_RESP;
      end
      ST_FILL: begin
        cmd.op = DP_FILL;
        if (stat.ptr_last) begin
          state_nxt = ST_RESP;
        end
      end
      // load the output register once it is free
      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          cmd.resp_ld   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hdl/text_terminal_scroll_buffer.sv
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// in        in_valid, in_stall, in_data             valid & !stall
// out       out_valid, out_stall, out_data          valid & !stall
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  valid & ready
//
// One item at a time: a new item is taken only once the last one's result is loaded.
// Clear sweeps the whole cell store. Each single-line scroll copies one cell per
// cycle and then blanks the last row; on the top row it blanks only that row's characters.
// After reset a clearing pass over every cell runs before the first item.
// A stalled result waits in the output register while the next item is taken.

module text_terminal_scroll_buffer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ttsb_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ttsb_pkg::out_item_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ttsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);
  import ttsb_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Colour registers are always writable
  assign cfg_ready = 1'b1;

  ttsb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ttsb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
